[sv/macr_pkg.sv]
package macr_pkg;

    localparam int ADDR_W = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_V_ALARM = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_V_WARN  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_C_ALARM = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_C_WARN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_F_ALARM = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_F_WARN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DB_VF   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DB_CP   = 3'd7;

    localparam logic [63:0] DB_VF_RESET = 64'h0000_0000_0001_0001;
    localparam logic [63:0] DB_CP_RESET = 64'h0000_0001_0000_000A;

    localparam logic [1:0] ST_GOOD   = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_NOCONN = 2'd2;
    localparam logic [1:0] ST_RSVD   = 2'd3;

    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_HIGH   = 2'd1;
    localparam logic [1:0] LVL_LOW    = 2'd2;

    typedef struct packed {
        logic [1:0]  read_status;
        logic [15:0] voltage_raw;
        logic [31:0] current_raw;
        logic [31:0] power_raw;
        logic [15:0] frequency_raw;
    } in_item_t;

    typedef struct packed {
        logic        report;
        logic [1:0]  status_out;
        logic [1:0]  voltage_level;
        logic [1:0]  current_level;
        logic [1:0]  frequency_level;
        logic [15:0] voltage_out;
        logic [31:0] current_out;
        logic [31:0] power_out;
        logic [15:0] frequency_out;
        logic        reconnect_request;
    } out_item_t;

    typedef struct packed {
        logic [63:0] v_alarm;
        logic [63:0] v_warn;
        logic [63:0] c_alarm;
        logic [63:0] c_warn;
        logic [63:0] f_alarm;
        logic [63:0] f_warn;
        logic [31:0] db_vf;
        logic [63:0] db_cp;
    } cfg_t;

endpackage

[sv/macr_level.sv]
module macr_level (
    input  logic [1:0]  prev,
    input  logic [31:0] x,
    input  logic [63:0] alarms,
    input  logic [63:0] warns,
    output logic [1:0]  level
);
    import macr_pkg::*;

    logic [31:0] ha;
    logic [31:0] la;
    logic [31:0] hw;
    logic [31:0] lw;

    assign ha = alarms[63:32];
    assign la = alarms[31:0];
    assign hw = warns[63:32];
    assign lw = warns[31:0];

    // alarm limits set the level, warning limits hold it
    always_comb
    begin
        if (ha == 32'd0)
            level = LVL_NORMAL;
        else if (x >= ha)
            level = LVL_HIGH;
        else if (x <= la)
            level = LVL_LOW;
        else if (prev == LVL_HIGH && x > hw)
            level = LVL_HIGH;
        else if (prev == LVL_LOW && x < lw)
            level = LVL_LOW;
        else
            level = LVL_NORMAL;
    end

endmodule

[sv/macr_regs.sv]
module macr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [macr_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output macr_pkg::cfg_t              cfg
);
    import macr_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr;
    logic [REG_IDX_W-1:0] idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_V_ALARM: cfg_next.v_alarm = pwdata;
                REG_V_WARN:  cfg_next.v_warn  = pwdata;
                REG_C_ALARM: cfg_next.c_alarm = pwdata;
                REG_C_WARN:  cfg_next.c_warn  = pwdata;
                REG_F_ALARM: cfg_next.f_alarm = pwdata;
                REG_F_WARN:  cfg_next.f_warn  = pwdata;
                REG_DB_VF:   cfg_next.db_vf   = pwdata[31:0];
                REG_DB_CP:   cfg_next.db_cp   = pwdata;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_V_ALARM: prdata = cfg_reg.v_alarm;
            REG_V_WARN:  prdata = cfg_reg.v_warn;
            REG_C_ALARM: prdata = cfg_reg.c_alarm;
            REG_C_WARN:  prdata = cfg_reg.c_warn;
            REG_F_ALARM: prdata = cfg_reg.f_alarm;
            REG_F_WARN:  prdata = cfg_reg.f_warn;
            REG_DB_VF:   prdata = {32'd0, cfg_reg.db_vf};
            REG_DB_CP:   prdata = cfg_reg.db_cp;
            default:     prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.v_alarm <= 64'd0;
            cfg_reg.v_warn  <= 64'd0;
            cfg_reg.c_alarm <= 64'd0;
            cfg_reg.c_warn  <= 64'd0;
            cfg_reg.f_alarm <= 64'd0;
            cfg_reg.f_warn  <= 64'd0;
            cfg_reg.db_vf   <= DB_VF_RESET[31:0];
            cfg_reg.db_cp   <= DB_CP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/macr_core.sv]
module macr_core #(
    parameter int FAILURE_LIMIT = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  macr_pkg::in_item_t  item,
    input  macr_pkg::cfg_t      cfg,
    output macr_pkg::out_item_t result
);
    import macr_pkg::*;

    localparam int CNT_W = $clog2(FAILURE_LIMIT + 2);

    logic [1:0]       v_lvl_reg, c_lvl_reg, f_lvl_reg;
    logic [1:0]       v_lvl_next, c_lvl_next, f_lvl_next;
    logic [15:0]      v_reg, v_next;
    logic [31:0]      c_reg, c_next;
    logic [31:0]      p_reg, p_next;
    logic [15:0]      f_reg, f_next;
    logic [1:0]       rep_status_reg, rep_status_next;
    logic [5:0]       rep_levels_reg, rep_levels_next;
    logic [15:0]      rep_v_reg, rep_v_next;
    logic [31:0]      rep_c_reg, rep_c_next;
    logic [31:0]      rep_p_reg, rep_p_next;
    logic [15:0]      rep_f_reg, rep_f_next;
    logic             first_reg, first_next;
    logic [CNT_W-1:0] fail_reg, fail_next;

    logic [1:0]       v_lvl_new, c_lvl_new, f_lvl_new;
    logic [1:0]       status;
    logic             good;
    logic [5:0]       levels;
    logic [15:0]      v_diff, f_diff;
    logic [31:0]      c_diff, p_diff;
    logic             moved_any;
    logic             report;
    logic [CNT_W-1:0] fail_inc;
    logic             reconnect;

    macr_level u_v_level (
        .prev   (v_lvl_reg),
        .x      ({16'd0, item.voltage_raw}),
        .alarms (cfg.v_alarm),
        .warns  (cfg.v_warn),
        .level  (v_lvl_new)
    );

    macr_level u_c_level (
        .prev   (c_lvl_reg),
        .x      (item.current_raw),
        .alarms (cfg.c_alarm),
        .warns  (cfg.c_warn),
        .level  (c_lvl_new)
    );

    macr_level u_f_level (
        .prev   (f_lvl_reg),
        .x      ({16'd0, item.frequency_raw}),
        .alarms (cfg.f_alarm),
        .warns  (cfg.f_warn),
        .level  (f_lvl_new)
    );

    // reserved status code counts as a failed read
    assign status = (item.read_status == ST_RSVD) ? ST_FAIL : item.read_status;
    assign good   = (status == ST_GOOD);

    assign v_lvl_next = good ? v_lvl_new : v_lvl_reg;
    assign c_lvl_next = good ? c_lvl_new : c_lvl_reg;
    assign f_lvl_next = good ? f_lvl_new : f_lvl_reg;
    assign v_next     = good ? item.voltage_raw : v_reg;
    assign c_next     = good ? item.current_raw : c_reg;
    assign p_next     = good ? item.power_raw : p_reg;
    assign f_next     = good ? item.frequency_raw : f_reg;

    assign levels = {f_lvl_next, c_lvl_next, v_lvl_next};

    assign v_diff = (v_next >= rep_v_reg) ? v_next - rep_v_reg : rep_v_reg - v_next;
    assign c_diff = (c_next >= rep_c_reg) ? c_next - rep_c_reg : rep_c_reg - c_next;
    assign p_diff = (p_next >= rep_p_reg) ? p_next - rep_p_reg : rep_p_reg - p_next;
    assign f_diff = (f_next >= rep_f_reg) ? f_next - rep_f_reg : rep_f_reg - f_next;

    assign moved_any = (v_diff > cfg.db_vf[31:16]) || (f_diff > cfg.db_vf[15:0])
                    || (c_diff > cfg.db_cp[63:32]) || (p_diff > cfg.db_cp[31:0]);

    assign report = first_reg || (status != rep_status_reg)
                 || (levels != rep_levels_reg) || moved_any;

    assign fail_inc  = fail_reg + CNT_W'(1);
    assign reconnect = !good && (fail_inc > CNT_W'(FAILURE_LIMIT));

    always_comb
    begin
        rep_status_next = rep_status_reg;
        rep_levels_next = rep_levels_reg;
        rep_v_next      = rep_v_reg;
        rep_c_next      = rep_c_reg;
        rep_p_next      = rep_p_reg;
        rep_f_next      = rep_f_reg;
        first_next      = first_reg;
        if (report)
        begin
            rep_status_next = status;
            rep_levels_next = levels;
            rep_v_next      = v_next;
            rep_c_next      = c_next;
            rep_p_next      = p_next;
            rep_f_next      = f_next;
            first_next      = 1'b0;
        end
        // restart the failure run on a good read or when it raises reconnect
        if (good || reconnect)
            fail_next = '0;
        else
            fail_next = fail_inc;
    end

    always_comb
    begin
        result.report            = report;
        result.status_out        = status;
        result.voltage_level     = v_lvl_next;
        result.current_level     = c_lvl_next;
        result.frequency_level   = f_lvl_next;
        result.voltage_out       = v_next;
        result.current_out       = c_next;
        result.power_out         = p_next;
        result.frequency_out     = f_next;
        result.reconnect_request = reconnect;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_lvl_reg      <= LVL_NORMAL;
            c_lvl_reg      <= LVL_NORMAL;
            f_lvl_reg      <= LVL_NORMAL;
            v_reg          <= '0;
            c_reg          <= '0;
            p_reg          <= '0;
            f_reg          <= '0;
            rep_status_reg <= ST_NOCONN;
            rep_levels_reg <= {LVL_NORMAL, LVL_NORMAL, LVL_NORMAL};
            rep_v_reg      <= '0;
            rep_c_reg      <= '0;
            rep_p_reg      <= '0;
            rep_f_reg      <= '0;
            first_reg      <= 1'b1;
            fail_reg       <= '0;
        end
        else if (fire)
        begin
            v_lvl_reg      <= v_lvl_next;
            c_lvl_reg      <= c_lvl_next;
            f_lvl_reg      <= f_lvl_next;
            v_reg          <= v_next;
            c_reg          <= c_next;
            p_reg          <= p_next;
            f_reg          <= f_next;
            rep_status_reg <= rep_status_next;
            rep_levels_reg <= rep_levels_next;
            rep_v_reg      <= rep_v_next;
            rep_c_reg      <= rep_c_next;
            rep_p_reg      <= rep_p_next;
            rep_f_reg      <= rep_f_next;
            first_reg      <= first_next;
            fail_reg       <= fail_next;
        end
    end

endmodule

[sv/meter_alarm_change_reporter.sv]
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------
// poll     | poll_valid/poll_ready | read status, raw V, I, P, f
// result   | result_valid/ready    | report flag, status, levels, values
// config   | APB psel/penable      | 64-bit limit and deadband registers
//
// One poll per cycle sustained while results are taken; a poll passes the input
// register, then the result register, and result_valid rises once it reaches
// the result register.
// The evaluation stage between the two registers holds all per-poll state.
// A stalled result holds the result register; the input register still
// takes one more poll, then poll_ready drops until the result moves.
// Reset clears levels, live and reported values and the failure run, and
// returns the config registers to their defaults.
module meter_alarm_change_reporter #(
    parameter int FAILURE_LIMIT = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        poll_valid,
    output logic                        poll_ready,
    input  macr_pkg::in_item_t          poll,
    output logic                        result_valid,
    input  logic                        result_ready,
    output macr_pkg::out_item_t         result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [macr_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import macr_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg, in_item_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    out_item_t eval_result;
    cfg_t      cfg;
    logic      fire;
    logic      poll_take;

    macr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    macr_core #(
        .FAILURE_LIMIT (FAILURE_LIMIT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (eval_result)
    );

    assign pready = 1'b1;

    // advance when the result register is empty or being drained
    assign fire       = in_valid_reg && (!out_valid_reg || result_ready);
    assign poll_ready = !in_valid_reg || fire;
    assign poll_take  = poll_valid && poll_ready;

    assign in_valid_next  = poll_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign in_item_next   = poll_take ? poll : in_item_reg;
    assign out_valid_next = fire ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    assign out_item_next  = fire ? eval_result : out_item_reg;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    a_no_rsvd_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status_out != ST_RSVD)
        else $error("reserved status code reached the result");

    a_reconnect_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.reconnect_request |-> result.status_out != ST_GOOD)
        else $error("reconnect request on a good read");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> poll_ready)
        else $error("poll stalled with an empty result register");

    a_fire_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid)
        else $error("evaluated poll did not reach the result register");

endmodule

[test/meter_checker.sv]
module meter_checker #(
    parameter int FAILURE_LIMIT = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        poll_valid,
    input  logic                        poll_ready,
    input  macr_pkg::in_item_t          poll,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  macr_pkg::out_item_t         result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [macr_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output int                          mismatches,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import macr_pkg::*;

    cfg_t        cfg;
    logic [1:0]  lvl_v, lvl_c, lvl_f;
    logic [15:0] live_v, live_f;
    logic [31:0] live_c, live_p;
    logic [1:0]  rep_status;
    logic [5:0]  rep_levels;
    logic [15:0] rep_v, rep_f;
    logic [31:0] rep_c, rep_p;
    logic        first_poll;
    int          failure_run;

    out_item_t   expected_results[$];
    out_item_t   want;

    function automatic logic [1:0] level_of(logic [1:0] prev, logic [31:0] x,
                                            logic [63:0] alarm, logic [63:0] warn);
        if (alarm[63:32] == 32'd0) return LVL_NORMAL;
        if (x >= alarm[63:32]) return LVL_HIGH;
        if (x <= alarm[31:0]) return LVL_LOW;
        if (prev == LVL_HIGH && x > warn[63:32]) return LVL_HIGH;
        if (prev == LVL_LOW && x < warn[31:0]) return LVL_LOW;
        return LVL_NORMAL;
    endfunction

    function automatic logic drifted(logic [31:0] a, logic [31:0] b, logic [31:0] band);
        return ((a >= b) ? a - b : b - a) > band;
    endfunction

    // Advance the meter state by one poll and return what the block must output.
    function automatic out_item_t meter_step(in_item_t p);
        logic [1:0] st;
        logic [5:0] lv;
        logic       rep;
        logic       recon;
        out_item_t  r;
        st = (p.read_status == ST_RSVD) ? ST_FAIL : p.read_status;
        recon = 1'b0;
        if (st == ST_GOOD) begin
            live_v = p.voltage_raw;
            live_c = p.current_raw;
            live_p = p.power_raw;
            live_f = p.frequency_raw;
            lvl_v = level_of(lvl_v, {16'd0, live_v}, cfg.v_alarm, cfg.v_warn);
            lvl_c = level_of(lvl_c, live_c, cfg.c_alarm, cfg.c_warn);
            lvl_f = level_of(lvl_f, {16'd0, live_f}, cfg.f_alarm, cfg.f_warn);
        end
        lv = {lvl_f, lvl_c, lvl_v};
        rep = first_poll || st != rep_status || lv != rep_levels
            || drifted({16'd0, live_v}, {16'd0, rep_v}, {16'd0, cfg.db_vf[31:16]})
            || drifted(live_c, rep_c, cfg.db_cp[63:32])
            || drifted({16'd0, live_f}, {16'd0, rep_f}, {16'd0, cfg.db_vf[15:0]})
            || drifted(live_p, rep_p, cfg.db_cp[31:0]);
        if (rep) begin
            rep_status = st;
            rep_levels = lv;
            rep_v = live_v;
            rep_c = live_c;
            rep_p = live_p;
            rep_f = live_f;
            first_poll = 1'b0;
        end
        if (st != ST_GOOD) begin
            failure_run++;
            if (failure_run > FAILURE_LIMIT) begin
                recon = 1'b1;
                failure_run = 0;
            end
        end else begin
            failure_run = 0;
        end
        r.report = rep;
        r.status_out = st;
        r.voltage_level = lvl_v;
        r.current_level = lvl_c;
        r.frequency_level = lvl_f;
        r.voltage_out = live_v;
        r.current_out = live_c;
        r.power_out = live_p;
        r.frequency_out = live_f;
        r.reconnect_request = recon;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    task automatic compare_field(string what, logic [63:0] got, logic [63:0] exp_val);
        if (got !== exp_val) report_mismatch(what, got, exp_val);
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg = '0;
            cfg.db_vf = DB_VF_RESET[31:0];
            cfg.db_cp = DB_CP_RESET;
            lvl_v = LVL_NORMAL;
            lvl_c = LVL_NORMAL;
            lvl_f = LVL_NORMAL;
            live_v = '0;
            live_c = '0;
            live_p = '0;
            live_f = '0;
            rep_status = ST_NOCONN;
            rep_levels = '0;
            rep_v = '0;
            rep_c = '0;
            rep_p = '0;
            rep_f = '0;
            first_poll = 1'b1;
            failure_run = 0;
            expected_results.delete();
            pending = 0;
        end else begin
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with nothing expected",
                                    64'd1, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("report", 64'(result.report), 64'(want.report));
                    compare_field("status_out", 64'(result.status_out),
                                  64'(want.status_out));
                    compare_field("voltage_level", 64'(result.voltage_level),
                                  64'(want.voltage_level));
                    compare_field("current_level", 64'(result.current_level),
                                  64'(want.current_level));
                    compare_field("frequency_level", 64'(result.frequency_level),
                                  64'(want.frequency_level));
                    compare_field("voltage_out", 64'(result.voltage_out),
                                  64'(want.voltage_out));
                    compare_field("current_out", 64'(result.current_out),
                                  64'(want.current_out));
                    compare_field("power_out", 64'(result.power_out), 64'(want.power_out));
                    compare_field("frequency_out", 64'(result.frequency_out),
                                  64'(want.frequency_out));
                    compare_field("reconnect_request", 64'(result.reconnect_request),
                                  64'(want.reconnect_request));
                end
            end
            if (poll_valid && poll_ready)
                expected_results.push_back(meter_step(poll));
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:3])
                    REG_V_ALARM: cfg.v_alarm = pwdata;
                    REG_V_WARN:  cfg.v_warn = pwdata;
                    REG_C_ALARM: cfg.c_alarm = pwdata;
                    REG_C_WARN:  cfg.c_warn = pwdata;
                    REG_F_ALARM: cfg.f_alarm = pwdata;
                    REG_F_WARN:  cfg.f_warn = pwdata;
                    REG_DB_VF:   cfg.db_vf = pwdata[31:0];
                    REG_DB_CP:   cfg.db_cp = pwdata;
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import macr_pkg::*;

    localparam int FAIL_LIMIT  = 10;
    localparam int LATENCY     = 3;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 110;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              poll_valid = 1'b0;
    logic              poll_ready;
    in_item_t          poll = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    out_item_t         result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;
    int                mismatches;
    int                pending;

    cfg_t              active;
    in_item_t          last_poll = '0;
    rx_mode_t          rx_mode = RX_OPEN;
    int                rx_left = 0;
    int                quiet_cycles = 0;

    always #5 clk = ~clk;

    meter_alarm_change_reporter #(.FAILURE_LIMIT(FAIL_LIMIT)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .poll_valid(poll_valid), .poll_ready(poll_ready), .poll(poll),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    meter_checker #(.FAILURE_LIMIT(FAIL_LIMIT)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .poll_valid(poll_valid), .poll_ready(poll_ready), .poll(poll),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .mismatches(mismatches), .pending(pending)
    );

    // Receiver: switch stall pattern every so often, including stretches with none.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  result_ready <= 1'b1;
            RX_LIGHT: result_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: result_ready <= ($urandom_range(0, 3) == 0);
            default:  result_ready <= ~result_ready;
        endcase
    end

    always @(posedge clk) begin
        if ((poll_valid && poll_ready) || (result_valid && result_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_item_t mk_poll(logic [1:0] st, logic [15:0] v, logic [31:0] c,
                                         logic [31:0] p, logic [15:0] f);
        in_item_t it;
        it.read_status = st;
        it.voltage_raw = v;
        it.current_raw = c;
        it.power_raw = p;
        it.frequency_raw = f;
        return it;
    endfunction

    // Mostly land near a threshold or drift from the last reading; sometimes anywhere.
    function automatic logic [31:0] pick_reading(logic [31:0] prev, logic [63:0] alarm,
                                                 logic [63:0] warn, logic [31:0] top);
        logic [31:0] anchor;
        case ($urandom_range(0, 9))
            0: return $urandom & top;
            1: return ($urandom_range(0, 1) != 0) ? top : 32'd0;
            2, 3, 4: return (prev + $urandom_range(0, 40) - 32'd20) & top;
            default: begin
                case ($urandom_range(0, 3))
                    0: anchor = alarm[63:32];
                    1: anchor = alarm[31:0];
                    2: anchor = warn[63:32];
                    default: anchor = warn[31:0];
                endcase
                return (anchor + $urandom_range(0, 6) - 32'd3) & top;
            end
        endcase
    endfunction

    function automatic in_item_t random_poll(logic storm);
        in_item_t it;
        int r;
        r = $urandom_range(0, 19);
        if (storm)
            it.read_status = (r < 12) ? ST_FAIL : (r < 17) ? ST_NOCONN : ST_RSVD;
        else
            it.read_status = (r < 14) ? ST_GOOD : (r < 17) ? ST_FAIL :
                             (r < 19) ? ST_NOCONN : ST_RSVD;
        it.voltage_raw = 16'(pick_reading({16'd0, last_poll.voltage_raw}, active.v_alarm,
                                          active.v_warn, 32'h0000_FFFF));
        it.current_raw = pick_reading(last_poll.current_raw, active.c_alarm, active.c_warn,
                                      32'hFFFF_FFFF);
        it.power_raw = pick_reading(last_poll.power_raw, 64'd0, 64'd0, 32'hFFFF_FFFF);
        it.frequency_raw = 16'(pick_reading({16'd0, last_poll.frequency_raw}, active.f_alarm,
                                            active.f_warn, 32'h0000_FFFF));
        return it;
    endfunction

    // Returns {alarm, warning}; mostly ordered low alarm <= low warning <= high warning < high alarm.
    function automatic logic [127:0] random_band(logic [31:0] top);
        logic [31:0] la, lw, hw, ha;
        la = $urandom & top;
        lw = (la + $urandom_range(0, 40)) & top;
        hw = (lw + $urandom_range(0, 300)) & top;
        ha = (hw + $urandom_range(1, 40)) & top;
        case ($urandom_range(0, 7))
            0: ha = 32'd0;
            1: return {$urandom, $urandom, $urandom, $urandom};
            default: ;
        endcase
        return {ha, la, hw, lw};
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        {s.v_alarm, s.v_warn} = random_band(32'h0000_FFFF);
        {s.c_alarm, s.c_warn} = random_band(32'hFFFF_FFFF);
        {s.f_alarm, s.f_warn} = random_band(32'h0000_FFFF);
        if ($urandom_range(0, 3) == 0) begin
            s.db_vf = $urandom;
            s.db_cp = {$urandom, $urandom};
        end else begin
            s.db_vf = {16'($urandom_range(0, 40)), 16'($urandom_range(0, 6))};
            s.db_cp = {32'($urandom_range(0, 40)), 32'($urandom_range(0, 30))};
        end
        return s;
    endfunction

    task automatic load_settings(cfg_t s);
        logic [63:0] vals [8];
        vals[REG_V_ALARM] = s.v_alarm;
        vals[REG_V_WARN]  = s.v_warn;
        vals[REG_C_ALARM] = s.c_alarm;
        vals[REG_C_WARN]  = s.c_warn;
        vals[REG_F_ALARM] = s.f_alarm;
        vals[REG_F_WARN]  = s.f_warn;
        vals[REG_DB_VF]   = {32'd0, s.db_vf};
        vals[REG_DB_CP]   = s.db_cp;
        for (int i = 0; i < 8; i++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_W'(i << 3);
            pwdata <= vals[i];
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            @(negedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        active = s;
    endtask

    // Call at a falling edge; leaves poll_valid high so the next transaction can follow.
    task automatic send_poll(in_item_t it);
        poll_valid <= 1'b1;
        poll <= it;
        last_poll = it;
        @(posedge clk);
        while (!poll_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result is back, then let the pipeline settle.
    task automatic drain_results();
        poll_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    initial begin
        in_item_t directed[$];
        cfg_t     typical;
        cfg_t     s;
        int       sent;
        int       burst;
        logic     storm;

        typical.v_alarm = {32'd2530, 32'd2070};
        typical.v_warn  = {32'd2480, 32'd2120};
        typical.c_alarm = {32'd16000, 32'd100};
        typical.c_warn  = {32'd15000, 32'd200};
        typical.f_alarm = {32'd510, 32'd490};
        typical.f_warn  = {32'd505, 32'd495};
        typical.db_vf   = {16'd20, 16'd2};
        typical.db_cp   = {32'd500, 32'd50};

        active = '0;
        active.db_vf = DB_VF_RESET[31:0];
        active.db_cp = DB_CP_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_settings(typical);
        directed.push_back(mk_poll(ST_GOOD, 16'd2300, 32'd5000, 32'd11500, 16'd500));
        directed.push_back(mk_poll(ST_GOOD, 16'd2300, 32'd5000, 32'd11500, 16'd500));
        // alarm edges, hold inside warning band, release at warning edge
        directed.push_back(mk_poll(ST_GOOD, 16'd2530, 32'd16000, 32'd11500, 16'd510));
        directed.push_back(mk_poll(ST_GOOD, 16'd2490, 32'd15500, 32'd11520, 16'd507));
        directed.push_back(mk_poll(ST_GOOD, 16'd2480, 32'd15000, 32'd11540, 16'd505));
        directed.push_back(mk_poll(ST_GOOD, 16'd2070, 32'd100, 32'd11500, 16'd490));
        directed.push_back(mk_poll(ST_GOOD, 16'd2100, 32'd150, 32'd11500, 16'd493));
        directed.push_back(mk_poll(ST_GOOD, 16'd2120, 32'd200, 32'd11500, 16'd495));
        directed.push_back(mk_poll(ST_GOOD, 16'd2300, 32'd5000, 32'd11500, 16'd500));
        // exactly at each deadband, then one past it
        directed.push_back(mk_poll(ST_GOOD, 16'd2320, 32'd5500, 32'd11550, 16'd502));
        directed.push_back(mk_poll(ST_GOOD, 16'd2321, 32'd5501, 32'd11551, 16'd503));
        directed.push_back(mk_poll(ST_GOOD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        directed.push_back(mk_poll(ST_GOOD, 16'd0, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk_poll(ST_FAIL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        directed.push_back(mk_poll(ST_NOCONN, 16'h1234, 32'h5678_9ABC, 32'h0F0F_0F0F, 16'h00FF));
        directed.push_back(mk_poll(ST_RSVD, 16'd0, 32'd0, 32'd0, 16'd0));
        // eight more failures make eleven in a row: reconnect
        repeat (8)
            directed.push_back(mk_poll(ST_FAIL, 16'd2300, 32'd5000, 32'd11500, 16'd500));
        directed.push_back(mk_poll(ST_GOOD, 16'd2300, 32'd5000, 32'd11500, 16'd500));
        foreach (directed[k]) send_poll(directed[k]);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    s = '0;
                    s.db_vf = DB_VF_RESET[31:0];
                    s.db_cp = DB_CP_RESET;
                end
                1: s = '0;
                2: s = '1;
                3: s = typical;
                default: s = random_settings();
            endcase
            load_settings(s);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                storm = ($urandom_range(0, 19) == 0);
                burst = storm ? $urandom_range(9, 14) : $urandom_range(1, 24);
                repeat (burst) begin
                    send_poll(random_poll(storm));
                    sent++;
                end
                case ($urandom_range(0, 9))
                    0: drain_results();
                    1, 2, 3: ;
                    default: begin
                        poll_valid <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(negedge clk);
                    end
                endcase
            end
            drain_results();
        end

        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
